[hdl/tlh_pkg.sv]
// ----------------------------------------------------------------------------
// tlh_pkg
// shared types, constants and helper functions of the touch link health tracker
// ----------------------------------------------------------------------------
package tlh_pkg;

	localparam int TimeW    = 63;
	localparam int CoordW   = 16;
	localparam int CntW     = 32;
	localparam int RunW     = 8;
	localparam int AgeW     = 32;
	localparam int LimitW   = 8;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;

	localparam logic [AgeW-1:0]   MaxAgeRst    = 32'd100000;
	localparam logic [LimitW-1:0] FailLimitRst = 8'd3;

	// event kinds
	typedef enum logic [1:0] {
		REQ_POLL    = 2'd0,
		REQ_RECOVER = 2'd1,
		REQ_PREVENT = 2'd2,
		REQ_QUERY   = 2'd3
	} req_kind_t;

	// register indexes on the config port
	typedef enum logic {
		REG_MAX_AGE    = 1'b0,
		REG_FAIL_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [AgeW-1:0]   max_age_us;
		logic [LimitW-1:0] failure_limit;
	} cfg_t;

	typedef struct packed {
		req_kind_t         req_type;
		logic [TimeW-1:0]  now_us;
		logic              bus_error;
		logic              has_frame;
		logic              frame_pressed;
		logic [CoordW-1:0] frame_x;
		logic [CoordW-1:0] frame_y;
	} item_t;

	typedef struct packed {
		logic              link_healthy;
		logic              touch_active;
		logic [CoordW-1:0] touch_x_out;
		logic [CoordW-1:0] touch_y_out;
		logic [CntW-1:0]   continuity_count;
		logic [CntW-1:0]   error_total;
		logic [RunW-1:0]   error_run;
		logic              in_recovery;
		logic              in_preventive_recovery;
		logic [CntW-1:0]   recovery_total;
		logic [CntW-1:0]   preventive_total;
	} res_t;

	// sample taken at then is fresh at now: no time reversal, age within limit
	function automatic logic fresh(input logic [TimeW-1:0] now,
			input logic [TimeW-1:0] then, input logic [AgeW-1:0] max_age);
		logic [TimeW-1:0] age;
		age = now - then;
		return (now >= then) && (age <= {{(TimeW-AgeW){1'b0}}, max_age});
	endfunction

	function automatic logic [CntW-1:0] sat_inc_cnt(input logic [CntW-1:0] v);
		return (v == {CntW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [RunW-1:0] sat_inc_run(input logic [RunW-1:0] v);
		return (v == {RunW{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

[hdl/tlh_cfg.sv]
// ----------------------------------------------------------------------------
// tlh_cfg
// apb register file holding the age limit and the failure limit
// ----------------------------------------------------------------------------
module tlh_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tlh_pkg::CfgAddrW-1:0] paddr,
	input  logic [tlh_pkg::CfgDataW-1:0] pwdata,
	output logic [tlh_pkg::CfgDataW-1:0] prdata,
	output logic                         pready,
	output tlh_pkg::cfg_t                cfg
);
	import tlh_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_age_us    <= MaxAgeRst;
			cfg_q.failure_limit <= FailLimitRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAX_AGE: begin
					cfg_q.max_age_us <= pwdata[AgeW-1:0];
				end
				REG_FAIL_LIMIT: begin
					cfg_q.failure_limit <= pwdata[LimitW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_AGE:    prdata = cfg_q.max_age_us;
			REG_FAIL_LIMIT: prdata = {{(CfgDataW-LimitW){1'b0}}, cfg_q.failure_limit};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[hdl/tlh_core.sv]
// ----------------------------------------------------------------------------
// tlh_core
// link state registers, per-event update and result evaluation
// ----------------------------------------------------------------------------
module tlh_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  tlh_pkg::item_t item,
	input  tlh_pkg::cfg_t  cfg,
	output tlh_pkg::res_t  res
);
	import tlh_pkg::*;

	logic                seen_q, last_failed_q, touch_valid_q, touch_down_q;
	logic [TimeW-1:0]    observed_time_q, frame_time_q;
	logic [CoordW-1:0]   pos_x_q, pos_y_q;
	logic [CntW-1:0]     continuity_q, errors_q, recoveries_q, preventives_q;
	logic [RunW-1:0]     error_run_q;
	logic                recovering_q, preventive_q;

	logic                seen_d, last_failed_d, touch_valid_d, touch_down_d;
	logic [TimeW-1:0]    observed_time_d, frame_time_d;
	logic [CoordW-1:0]   pos_x_d, pos_y_d;
	logic [CntW-1:0]     continuity_d, errors_d, recoveries_d, preventives_d;
	logic [RunW-1:0]     error_run_d;
	logic                recovering_d, preventive_d;
	logic                obs_fresh_d, frame_fresh_d, healthy;

	always_comb begin
		logic obs_fresh, frame_fresh, stale, withdraw;
		obs_fresh   = fresh(item.now_us, observed_time_q, cfg.max_age_us);
		frame_fresh = fresh(item.now_us, frame_time_q, cfg.max_age_us);
		stale       = (seen_q && !obs_fresh) ||
		              (touch_valid_q && touch_down_q && !frame_fresh);
		withdraw    = 1'b0;

		seen_d          = seen_q;
		observed_time_d = observed_time_q;
		frame_time_d    = frame_time_q;
		last_failed_d   = last_failed_q;
		touch_valid_d   = touch_valid_q;
		touch_down_d    = touch_down_q;
		pos_x_d         = pos_x_q;
		pos_y_d         = pos_y_q;
		errors_d        = errors_q;
		error_run_d     = error_run_q;
		recovering_d    = recovering_q;
		preventive_d    = preventive_q;
		recoveries_d    = recoveries_q;
		preventives_d   = preventives_q;
		obs_fresh_d     = obs_fresh;
		frame_fresh_d   = frame_fresh;

		unique case (item.req_type)
			REQ_POLL: begin
				withdraw        = stale || item.bus_error;
				seen_d          = 1'b1;
				observed_time_d = item.now_us;
				obs_fresh_d     = 1'b1;
				last_failed_d   = item.bus_error;
				if (item.bus_error) begin
					errors_d    = sat_inc_cnt(errors_q);
					error_run_d = sat_inc_run(error_run_q);
				end else begin
					error_run_d  = '0;
					recovering_d = 1'b0;
					preventive_d = 1'b0;
				end
			end
			REQ_RECOVER, REQ_PREVENT: begin
				withdraw     = 1'b1;
				recovering_d = 1'b1;
				preventive_d = (item.req_type == REQ_PREVENT);
				recoveries_d = sat_inc_cnt(recoveries_q);
				if (item.req_type == REQ_PREVENT) begin
					preventives_d = sat_inc_cnt(preventives_q);
				end
			end
			REQ_QUERY: begin
			end
			default: begin
			end
		endcase

		// one withdrawal bumps continuity at most once
		continuity_d = (withdraw && (touch_valid_q || touch_down_q)) ?
		               continuity_q + 1'b1 : continuity_q;
		if (withdraw) begin
			touch_valid_d = 1'b0;
			touch_down_d  = 1'b0;
		end

		// good poll with a frame stores it, after any withdrawal
		if (item.req_type == REQ_POLL && !item.bus_error && item.has_frame) begin
			frame_time_d  = item.now_us;
			frame_fresh_d = 1'b1;
			touch_valid_d = 1'b1;
			touch_down_d  = item.frame_pressed;
			pos_x_d       = item.frame_x;
			pos_y_d       = item.frame_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q          <= 1'b0;
			observed_time_q <= '0;
			frame_time_q    <= '0;
			last_failed_q   <= 1'b0;
			touch_valid_q   <= 1'b0;
			touch_down_q    <= 1'b0;
			pos_x_q         <= '0;
			pos_y_q         <= '0;
			continuity_q    <= '0;
			errors_q        <= '0;
			error_run_q     <= '0;
			recovering_q    <= 1'b0;
			preventive_q    <= 1'b0;
			recoveries_q    <= '0;
			preventives_q   <= '0;
		end else if (step) begin
			seen_q          <= seen_d;
			observed_time_q <= observed_time_d;
			frame_time_q    <= frame_time_d;
			last_failed_q   <= last_failed_d;
			touch_valid_q   <= touch_valid_d;
			touch_down_q    <= touch_down_d;
			pos_x_q         <= pos_x_d;
			pos_y_q         <= pos_y_d;
			continuity_q    <= continuity_d;
			errors_q        <= errors_d;
			error_run_q     <= error_run_d;
			recovering_q    <= recovering_d;
			preventive_q    <= preventive_d;
			recoveries_q    <= recoveries_d;
			preventives_q   <= preventives_d;
		end
	end

	assign healthy = seen_d && !recovering_d && (error_run_d < cfg.failure_limit) &&
	                 obs_fresh_d;

	always_comb begin
		res.link_healthy           = healthy;
		res.touch_active           = healthy && !last_failed_d && touch_valid_d &&
		                             touch_down_d && frame_fresh_d;
		res.touch_x_out            = pos_x_d;
		res.touch_y_out            = pos_y_d;
		res.continuity_count       = continuity_d;
		res.error_total            = errors_d;
		res.error_run              = error_run_d;
		res.in_recovery            = recovering_d;
		res.in_preventive_recovery = preventive_d;
		res.recovery_total         = recoveries_d;
		res.preventive_total       = preventives_d;
	end

endmodule

[hdl/touch_link_health_tracker.sv]
// ----------------------------------------------------------------------------
// touch_link_health_tracker
// follows touch controller link health from timestamped events
// ----------------------------------------------------------------------------
// order: an accepted event moves on from stage 1 once the result register is
//   free or drains; its result is loaded there and offered from then on
// throughput: one event per cycle unless the result register stalls; the state
//   update and result evaluation take a single core pass from input to result reg
// reset: arst_n clears all link state and counters to zero and loads the age
//   limit with 100000 us and the failure limit with 3
module touch_link_health_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tlh_pkg::CfgAddrW-1:0] paddr,
	input  logic [tlh_pkg::CfgDataW-1:0] pwdata,
	output logic [tlh_pkg::CfgDataW-1:0] prdata,
	output logic                         pready,
	// event channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   req_type,
	input  logic [tlh_pkg::TimeW-1:0]    now_us,
	input  logic                         bus_error,
	input  logic                         has_frame,
	input  logic                         frame_pressed,
	input  logic [tlh_pkg::CoordW-1:0]   frame_x,
	input  logic [tlh_pkg::CoordW-1:0]   frame_y,
	// result channel
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         link_healthy,
	output logic                         touch_active,
	output logic [tlh_pkg::CoordW-1:0]   touch_x_out,
	output logic [tlh_pkg::CoordW-1:0]   touch_y_out,
	output logic [tlh_pkg::CntW-1:0]     continuity_count,
	output logic [tlh_pkg::CntW-1:0]     error_total,
	output logic [tlh_pkg::RunW-1:0]     error_run,
	output logic                         in_recovery,
	output logic                         in_preventive_recovery,
	output logic [tlh_pkg::CntW-1:0]     recovery_total,
	output logic [tlh_pkg::CntW-1:0]     preventive_total
);
	import tlh_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_comb;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;

	// config registers
	tlh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the event in stage 1 moves on once the result register is free or drains;
	// the state update happens in the same cycle, so events stay in order
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// stage 1 payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1.req_type      <= req_kind_t'(req_type);
			item_s1.now_us        <= now_us;
			item_s1.bus_error     <= bus_error;
			item_s1.has_frame     <= has_frame;
			item_s1.frame_pressed <= frame_pressed;
			item_s1.frame_x       <= frame_x;
			item_s1.frame_y       <= frame_y;
		end
	end

	// link state and single-pass evaluation
	tlh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign rsp_valid              = valid_s2;
	assign link_healthy           = res_s2.link_healthy;
	assign touch_active           = res_s2.touch_active;
	assign touch_x_out            = res_s2.touch_x_out;
	assign touch_y_out            = res_s2.touch_y_out;
	assign continuity_count       = res_s2.continuity_count;
	assign error_total            = res_s2.error_total;
	assign error_run              = res_s2.error_run;
	assign in_recovery            = res_s2.in_recovery;
	assign in_preventive_recovery = res_s2.in_preventive_recovery;
	assign recovery_total         = res_s2.recovery_total;
	assign preventive_total       = res_s2.preventive_total;

`ifndef SYNTHESIS
	// a link in recovery is never reported healthy
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(in_recovery && link_healthy))
		else $error("healthy link reported during recovery");

	// an active touch needs a healthy link
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!touch_active || link_healthy))
		else $error("touch active on unhealthy link");

	// a preventive recovery is a kind of recovery
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!in_preventive_recovery || in_recovery))
		else $error("preventive flag without recovery");

	// preventive starts are counted among all recovery starts
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (preventive_total <= recovery_total))
		else $error("preventive total exceeds recovery total");
`endif

endmodule

[tb/link_health_checker.sv]
// ----------------------------------------------------------------------------
// link_health_checker
// follows the event and result channels of the touch link health tracker,
// keeps its own copy of the link state and config, and compares every result
// transaction field by field with the oldest expected one
// ----------------------------------------------------------------------------
module link_health_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	// config port, watched for register writes
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [tlh_pkg::CfgAddrW-1:0] paddr,
	input  logic [tlh_pkg::CfgDataW-1:0] pwdata,
	// event channel
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic [1:0]                   req_type,
	input  logic [tlh_pkg::TimeW-1:0]    now_us,
	input  logic                         bus_error,
	input  logic                         has_frame,
	input  logic                         frame_pressed,
	input  logic [tlh_pkg::CoordW-1:0]   frame_x,
	input  logic [tlh_pkg::CoordW-1:0]   frame_y,
	// result channel
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic                         link_healthy,
	input  logic                         touch_active,
	input  logic [tlh_pkg::CoordW-1:0]   touch_x_out,
	input  logic [tlh_pkg::CoordW-1:0]   touch_y_out,
	input  logic [tlh_pkg::CntW-1:0]     continuity_count,
	input  logic [tlh_pkg::CntW-1:0]     error_total,
	input  logic [tlh_pkg::RunW-1:0]     error_run,
	input  logic                         in_recovery,
	input  logic                         in_preventive_recovery,
	input  logic [tlh_pkg::CntW-1:0]     recovery_total,
	input  logic [tlh_pkg::CntW-1:0]     preventive_total,
	output int                           mismatches,
	output int                           pending
);
	import tlh_pkg::*;

	logic [AgeW-1:0]   age_limit;
	logic [LimitW-1:0] fail_limit;

	logic              seen;
	logic [TimeW-1:0]  obs_stamp;
	logic [TimeW-1:0]  frame_stamp;
	logic              poll_failed;
	logic              touch_ok;
	logic              pressed;
	logic [CoordW-1:0] x_pos;
	logic [CoordW-1:0] y_pos;
	logic [CntW-1:0]   breaks;
	logic [CntW-1:0]   err_count;
	logic [RunW-1:0]   err_streak;
	logic              recovering;
	logic              preventive;
	logic [CntW-1:0]   recov_count;
	logic [CntW-1:0]   prevent_count;

	res_t expected_reports[$];

	function automatic logic within_age(input logic [TimeW-1:0] now,
			input logic [TimeW-1:0] then);
		return (now >= then) && ((now - then) <= TimeW'(age_limit));
	endfunction

	// a touch that was valid or pressed breaks continuity when withdrawn
	function automatic void withdraw_touch();
		if (touch_ok || pressed)
			breaks = breaks + 1'b1;
		touch_ok = 1'b0;
		pressed  = 1'b0;
	endfunction

	function automatic res_t predict_report(input item_t ev);
		res_t r;
		case (ev.req_type)
			REQ_POLL: begin
				if ((seen && !within_age(ev.now_us, obs_stamp)) ||
						(touch_ok && pressed && !within_age(ev.now_us, frame_stamp)))
					withdraw_touch();
				seen        = 1'b1;
				obs_stamp   = ev.now_us;
				poll_failed = ev.bus_error;
				if (ev.bus_error) begin
					withdraw_touch();
					if (err_count != '1)
						err_count = err_count + 1'b1;
					if (err_streak != '1)
						err_streak = err_streak + 1'b1;
				end else begin
					err_streak = '0;
					recovering = 1'b0;
					preventive = 1'b0;
					if (ev.has_frame) begin
						frame_stamp = ev.now_us;
						touch_ok    = 1'b1;
						pressed     = ev.frame_pressed;
						x_pos       = ev.frame_x;
						y_pos       = ev.frame_y;
					end
				end
			end
			REQ_RECOVER, REQ_PREVENT: begin
				withdraw_touch();
				recovering = 1'b1;
				preventive = (ev.req_type == REQ_PREVENT);
				if (recov_count != '1)
					recov_count = recov_count + 1'b1;
				if (preventive && prevent_count != '1)
					prevent_count = prevent_count + 1'b1;
			end
			default: ;
		endcase
		r.link_healthy = seen && !recovering && (err_streak < fail_limit) &&
			within_age(ev.now_us, obs_stamp);
		r.touch_active = r.link_healthy && !poll_failed && touch_ok && pressed &&
			within_age(ev.now_us, frame_stamp);
		r.touch_x_out            = x_pos;
		r.touch_y_out            = y_pos;
		r.continuity_count       = breaks;
		r.error_total            = err_count;
		r.error_run              = err_streak;
		r.in_recovery            = recovering;
		r.in_preventive_recovery = preventive;
		r.recovery_total         = recov_count;
		r.preventive_total       = prevent_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t ev;
		res_t  want;
		if (!arst_n) begin
			age_limit     = MaxAgeRst;
			fail_limit    = FailLimitRst;
			seen          = 1'b0;
			obs_stamp     = '0;
			frame_stamp   = '0;
			poll_failed   = 1'b0;
			touch_ok      = 1'b0;
			pressed       = 1'b0;
			x_pos         = '0;
			y_pos         = '0;
			breaks        = '0;
			err_count     = '0;
			err_streak    = '0;
			recovering    = 1'b0;
			preventive    = 1'b0;
			recov_count   = '0;
			prevent_count = '0;
			expected_reports.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no event outstanding");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("link_healthy", want.link_healthy, link_healthy);
					check_field("touch_active", want.touch_active, touch_active);
					check_field("touch_x_out", want.touch_x_out, touch_x_out);
					check_field("touch_y_out", want.touch_y_out, touch_y_out);
					check_field("continuity_count", want.continuity_count, continuity_count);
					check_field("error_total", want.error_total, error_total);
					check_field("error_run", want.error_run, error_run);
					check_field("in_recovery", want.in_recovery, in_recovery);
					check_field("in_preventive_recovery", want.in_preventive_recovery,
						in_preventive_recovery);
					check_field("recovery_total", want.recovery_total, recovery_total);
					check_field("preventive_total", want.preventive_total, preventive_total);
				end
			end
			if (req_valid && req_ready) begin
				ev.req_type      = req_kind_t'(req_type);
				ev.now_us        = now_us;
				ev.bus_error     = bus_error;
				ev.has_frame     = has_frame;
				ev.frame_pressed = frame_pressed;
				ev.frame_x       = frame_x;
				ev.frame_y       = frame_y;
				expected_reports.push_back(predict_report(ev));
			end
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (paddr[CfgAddrW-1:2])
					REG_MAX_AGE:    age_limit  = pwdata[AgeW-1:0];
					REG_FAIL_LIMIT: fail_limit = pwdata[LimitW-1:0];
					default: ;
				endcase
			end
			pending = expected_reports.size();
		end
	end

endmodule

[tb/touch_link_health_tracker_tb.sv]
// ----------------------------------------------------------------------------
// touch_link_health_tracker_tb
// drives timestamped link events into the tracker under bursty sending and a
// stalling receiver, walks the age and failure limits through several settings
// and leaves all checking to link_health_checker; prints the verdict at the end
// ----------------------------------------------------------------------------
module touch_link_health_tracker_tb;
	import tlh_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	// receiver stall patterns
	localparam int unsigned ReadyAlways = 0;
	localparam int unsigned ReadyCoin   = 1;
	localparam int unsigned ReadyPulse  = 2;
	localparam int unsigned ReadyHold   = 3;

	logic clk = 1'b0;
	logic arst_n;

	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [CfgDataW-1:0] pwdata;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	logic                req_valid;
	logic                req_ready;
	logic [1:0]          req_type;
	logic [TimeW-1:0]    now_us;
	logic                bus_error;
	logic                has_frame;
	logic                frame_pressed;
	logic [CoordW-1:0]   frame_x;
	logic [CoordW-1:0]   frame_y;

	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic                link_healthy;
	logic                touch_active;
	logic [CoordW-1:0]   touch_x_out;
	logic [CoordW-1:0]   touch_y_out;
	logic [CntW-1:0]     continuity_count;
	logic [CntW-1:0]     error_total;
	logic [RunW-1:0]     error_run;
	logic                in_recovery;
	logic                in_preventive_recovery;
	logic [CntW-1:0]     recovery_total;
	logic [CntW-1:0]     preventive_total;

	int mismatch_total;
	int reports_pending;

	// stimulus bookkeeping
	logic [TimeW-1:0] stamp_us;
	logic [AgeW-1:0]  cur_age;
	int unsigned      burst_left;
	int unsigned      cycle_count;
	int unsigned      ready_mode;
	int unsigned      ready_left;

	always #6 clk = ~clk;

	touch_link_health_tracker dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready),
		.req_valid              (req_valid),
		.req_ready              (req_ready),
		.req_type               (req_type),
		.now_us                 (now_us),
		.bus_error              (bus_error),
		.has_frame              (has_frame),
		.frame_pressed          (frame_pressed),
		.frame_x                (frame_x),
		.frame_y                (frame_y),
		.rsp_valid              (rsp_valid),
		.rsp_ready              (rsp_ready),
		.link_healthy           (link_healthy),
		.touch_active           (touch_active),
		.touch_x_out            (touch_x_out),
		.touch_y_out            (touch_y_out),
		.continuity_count       (continuity_count),
		.error_total            (error_total),
		.error_run              (error_run),
		.in_recovery            (in_recovery),
		.in_preventive_recovery (in_preventive_recovery),
		.recovery_total         (recovery_total),
		.preventive_total       (preventive_total)
	);

	link_health_checker checker_i (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.pready                 (pready),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.req_valid              (req_valid),
		.req_ready              (req_ready),
		.req_type               (req_type),
		.now_us                 (now_us),
		.bus_error              (bus_error),
		.has_frame              (has_frame),
		.frame_pressed          (frame_pressed),
		.frame_x                (frame_x),
		.frame_y                (frame_y),
		.rsp_valid              (rsp_valid),
		.rsp_ready              (rsp_ready),
		.link_healthy           (link_healthy),
		.touch_active           (touch_active),
		.touch_x_out            (touch_x_out),
		.touch_y_out            (touch_y_out),
		.continuity_count       (continuity_count),
		.error_total            (error_total),
		.error_run              (error_run),
		.in_recovery            (in_recovery),
		.in_preventive_recovery (in_preventive_recovery),
		.recovery_total         (recovery_total),
		.preventive_total       (preventive_total),
		.mismatches             (mismatch_total),
		.pending                (reports_pending)
	);

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: picks a stall pattern, keeps it for a while, then picks again
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(ReadyAlways, ReadyHold);
			ready_left = $urandom_range(5, 40);
		end
		ready_left--;
		case (ready_mode)
			ReadyAlways: rsp_ready <= 1'b1;
			ReadyCoin:   rsp_ready <= 1'($urandom_range(0, 1));
			ReadyPulse:  rsp_ready <= (ready_left % 7) < 2;
			default:     rsp_ready <= 1'b0;
		endcase
	end

	// one event transaction; the sender idles between bursts of random length,
	// and valid is only lowered when a real gap follows
	task automatic send_event(input item_t ev);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_type      <= ev.req_type;
		now_us        <= ev.now_us;
		bus_error     <= ev.bus_error;
		has_frame     <= ev.has_frame;
		frame_pressed <= ev.frame_pressed;
		frame_x       <= ev.frame_x;
		frame_y       <= ev.frame_y;
		req_valid     <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_at(input req_kind_t kind, input logic [TimeW-1:0] at,
			input logic err, input logic frame, input logic press,
			input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
		item_t ev;
		ev.req_type      = kind;
		ev.now_us        = at;
		ev.bus_error     = err;
		ev.has_frame     = frame;
		ev.frame_pressed = press;
		ev.frame_x       = x;
		ev.frame_y       = y;
		stamp_us = at;
		send_event(ev);
	endtask

	// sender lowers valid and holds off until every result is back
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		while (reports_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CfgDataW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CfgAddrW'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reconfigure(input logic [AgeW-1:0] age, input logic [LimitW-1:0] limit);
		drain();
		cfg_write(REG_MAX_AGE, CfgDataW'(age));
		cfg_write(REG_FAIL_LIMIT, CfgDataW'(limit));
		cur_age = age;
	endtask

	// mostly small forward steps around the age limit, sometimes time runs
	// backwards or jumps anywhere in the 63-bit range
	function automatic logic [TimeW-1:0] next_stamp(input logic [TimeW-1:0] t,
			input logic [AgeW-1:0] age);
		logic [63:0] step;
		int unsigned pick;
		int unsigned zero_cut;
		pick = $urandom_range(0, 99);
		zero_cut = (age == 0) ? 40 : 10;
		if (pick < zero_cut)
			step = '0;
		else if (pick < 50)
			step = 64'($urandom_range(1, 4));
		else if (pick < 75)
			step = 64'($urandom_range(0, age));
		else if (pick < 82)
			step = 64'(age);
		else if (pick < 89)
			step = 64'(age) + 64'd1;
		else if (pick < 95)
			return t - TimeW'($urandom_range(1, 5000));
		else
			return TimeW'({$urandom, $urandom});
		return t + step[TimeW-1:0];
	endfunction

	function automatic item_t random_event(input logic [TimeW-1:0] t);
		item_t ev;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		ev.req_type      = (pick < 60) ? REQ_POLL : (pick < 70) ? REQ_RECOVER :
			(pick < 80) ? REQ_PREVENT : REQ_QUERY;
		ev.now_us        = t;
		ev.bus_error     = $urandom_range(0, 99) < 15;
		ev.has_frame     = $urandom_range(0, 99) < 65;
		ev.frame_pressed = $urandom_range(0, 99) < 70;
		ev.frame_x       = CoordW'($urandom);
		ev.frame_y       = CoordW'($urandom);
		return ev;
	endfunction

	// random traffic with occasional runs of failed polls to cross the limit
	task automatic run_random(input int unsigned count);
		item_t ev;
		int unsigned streak;
		streak = 0;
		repeat (count) begin
			stamp_us = next_stamp(stamp_us, cur_age);
			ev = random_event(stamp_us);
			if (streak == 0 && $urandom_range(0, 99) < 5)
				streak = $urandom_range(1, 6);
			if (streak != 0) begin
				ev.req_type  = REQ_POLL;
				ev.bus_error = 1'b1;
				streak--;
			end
			send_event(ev);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_valid     = 1'b0;
		req_type      = REQ_QUERY;
		now_us        = '0;
		bus_error     = 1'b0;
		has_frame     = 1'b0;
		frame_pressed = 1'b0;
		frame_x       = '0;
		frame_y       = '0;
		stamp_us      = '0;
		cur_age       = MaxAgeRst;
		burst_left    = 0;
		cycle_count   = 0;
		ready_mode    = ReadyAlways;
		ready_left    = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset limits (100000 us, 3 errors)
		// query before any observation: never healthy
		send_at(REQ_QUERY, 0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_POLL, 10, 1'b0, 1'b1, 1'b1, 16'hffff, 16'h0000);
		// age exactly at the limit, then one past it
		send_at(REQ_QUERY, 100010, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_QUERY, 100011, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		// stale observation and frame withdraw the touch before the new frame
		send_at(REQ_POLL, 200000, 1'b0, 1'b1, 1'b1, 16'h0000, 16'hffff);
		send_at(REQ_POLL, 200050, 1'b0, 1'b0, 1'b1, 16'h1234, 16'h5678);
		// time running backwards
		send_at(REQ_POLL, 100, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_POLL, 150, 1'b0, 1'b1, 1'b1, 16'h00aa, 16'h0055);
		// failed polls ignore the frame and build the error run up to the limit
		send_at(REQ_POLL, 160, 1'b1, 1'b1, 1'b1, 16'hdead, 16'hbeef);
		send_at(REQ_POLL, 170, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_POLL, 180, 1'b1, 1'b1, 1'b0, 16'hffff, 16'hffff);
		// good poll with a released frame
		send_at(REQ_POLL, 190, 1'b0, 1'b1, 1'b0, 16'h0101, 16'h0202);
		send_at(REQ_RECOVER, 200, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_PREVENT, 210, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_QUERY, 220, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		// a good poll ends the recovery
		send_at(REQ_POLL, 230, 1'b0, 1'b1, 1'b1, 16'h7fff, 16'h8000);
		// recovery while pressed, then a failed poll during recovery
		send_at(REQ_RECOVER, 240, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_POLL, 250, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_POLL, 260, 1'b0, 1'b1, 1'b1, 16'h4321, 16'h8765);
		// top of the time range
		send_at(REQ_POLL, {TimeW{1'b1}}, 1'b0, 1'b1, 1'b1, 16'hffff, 16'hffff);
		send_at(REQ_QUERY, {TimeW{1'b1}}, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_QUERY, 0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_PREVENT, 5, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_at(REQ_RECOVER, 6, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);

		// zero age and zero failure limit: the link can never be healthy
		reconfigure('0, '0);
		run_random(40);

		// widest age and failure limit, plus a failed-poll run long enough to
		// saturate the consecutive error count
		reconfigure('1, '1);
		run_random(30);
		repeat (262) begin
			stamp_us = stamp_us + 1'b1;
			send_at(REQ_POLL, stamp_us, 1'b1, 1'($urandom), 1'($urandom),
				CoordW'($urandom), CoordW'($urandom));
		end
		run_random(20);

		// short age, a single error is enough
		reconfigure(AgeW'(50), LimitW'(1));
		run_random(50);

		// back to the reset limits; pause mid-way until every result is back
		reconfigure(MaxAgeRst, FailLimitRst);
		run_random(30);
		drain();
		run_random(30);

		// random limits
		reconfigure(AgeW'($urandom_range(0, 200000)), LimitW'($urandom_range(0, 8)));
		run_random(40);

		drain();
		if (mismatch_total == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
